@@ hdl/dfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Drive filename parser package
// Shared types and character constants for the drive filename parser.
// ----------------------------------------------------------------------------
package dfp_pkg;

    localparam int NAME_LEN_DEF = 13;
    localparam int EXT_LEN_DEF  = 3;
    localparam int MAX_BEATS    = 16;

    localparam logic [7:0] DEFAULT_DRIVE_RST = 8'h41;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_CTRL  = 8'h20;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP1,
        PH_LOOK,
        PH_SKIP2,
        PH_NAME,
        PH_DOTCHK,
        PH_EXT
    } t_phase;

    typedef struct packed {
        logic        valid;
        logic [7:0]  drive;
    } t_bad;

    typedef struct packed {
        logic        start;
        logic [7:0]  drive;
        logic [15:0] consumed;
    } t_burst;

endpackage

@@ hdl/dfp_core.sv @@
// ----------------------------------------------------------------------------
// Drive filename parser core
// Input register, default drive register and the per-byte parse step.
// ----------------------------------------------------------------------------
module dfp_core #(
    parameter int NAME_LEN = dfp_pkg::NAME_LEN_DEF,
    parameter int EXT_LEN  = dfp_pkg::EXT_LEN_DEF,
    localparam int TOTAL   = NAME_LEN + EXT_LEN,
    localparam int AW      = $clog2(TOTAL),
    localparam int CW      = $clog2(TOTAL + 1),
    localparam int NW      = $clog2(NAME_LEN + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_first,
    output logic                 o_in_stall,
    input  logic                 i_cfg_valid,
    input  logic [7:0]           i_cfg_default_drive,
    output logic                 o_cfg_ready,
    input  logic                 i_emit_busy,
    input  logic                 i_out_free,
    output logic                 o_wr_en,
    output logic [AW-1:0]        o_wr_addr,
    output logic [7:0]           o_wr_data,
    output dfp_pkg::t_burst      o_burst,
    output logic [NW-1:0]        o_nfill,
    output logic [CW-1:0]        o_cnt,
    output dfp_pkg::t_bad        o_bad
);

    localparam logic [CW-1:0] NAME_C  = CW'(NAME_LEN);
    localparam logic [CW-1:0] TOTAL_C = CW'(TOTAL);

    typedef struct packed {
        dfp_pkg::t_phase phase;
        logic [CW-1:0]   cnt;
        logic [NW-1:0]   nfill;
        logic [15:0]     cons;
        logic            we;
        logic [AW-1:0]   waddr;
        logic            burst;
    } t_txt;

    function automatic t_txt text_step(input t_txt s, input logic [7:0] c);
        t_txt o;
        logic ctrl;
        logic done;
        o       = s;
        o.we    = 1'b0;
        o.burst = 1'b0;
        o.waddr = s.cnt[AW-1:0];
        done    = 1'b0;
        ctrl    = (c < dfp_pkg::CH_CTRL) || (c == dfp_pkg::CH_COLON);
        if (o.phase == dfp_pkg::PH_SKIP2) begin
            if (c == dfp_pkg::CH_SPACE) begin
                o.cons = o.cons + 16'd1;
                done   = 1'b1;
            end else begin
                o.phase = dfp_pkg::PH_NAME;
            end
        end
        if (!done && o.phase == dfp_pkg::PH_NAME) begin
            done = 1'b1;
            if (c == dfp_pkg::CH_DOT) begin
                o.cons  = o.cons + 16'd1;
                o.nfill = NW'(o.cnt);
                o.cnt   = NAME_C;
                o.phase = dfp_pkg::PH_EXT;
            end else if (ctrl) begin
                o.burst = 1'b1;
                o.phase = dfp_pkg::PH_IDLE;
            end else begin
                o.we    = 1'b1;
                o.cnt   = o.cnt + CW'(1);
                o.cons  = o.cons + 16'd1;
                o.nfill = NW'(o.cnt);
                if (o.cnt >= NAME_C) begin
                    o.phase = dfp_pkg::PH_DOTCHK;
                end
            end
        end
        if (!done && o.phase == dfp_pkg::PH_DOTCHK) begin
            o.phase = dfp_pkg::PH_EXT;
            if (c == dfp_pkg::CH_DOT) begin
                o.cons = o.cons + 16'd1;
                done   = 1'b1;
            end
        end
        if (!done && o.phase == dfp_pkg::PH_EXT) begin
            if (ctrl) begin
                o.burst = 1'b1;
                o.phase = dfp_pkg::PH_IDLE;
            end else begin
                o.we   = 1'b1;
                o.cnt  = o.cnt + CW'(1);
                o.cons = o.cons + 16'd1;
                if (o.cnt >= TOTAL_C) begin
                    o.burst = 1'b1;
                    o.phase = dfp_pkg::PH_IDLE;
                end
            end
        end
        return o;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] d);
        if (d >= dfp_pkg::CH_LC_A && d <= dfp_pkg::CH_LC_Z) begin
            return d - dfp_pkg::CASE_BIT;
        end
        return d;
    endfunction

    function automatic logic drive_ok(input logic [7:0] d);
        return d inside {[dfp_pkg::CH_A:dfp_pkg::CH_L], dfp_pkg::CH_T, dfp_pkg::CH_S,
                         dfp_pkg::CH_Q};
    endfunction

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_first;
    logic [7:0]      r_default;
    dfp_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_held, n_held;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [NW-1:0]   r_nfill, n_nfill;
    logic [15:0]     r_cons, n_cons;
    logic [7:0]      r_drive, n_drive;

    t_txt            base, t1, t2;
    logic [7:0]      held_b, drive_b, up;
    logic            res_bad;
    logic            res_burst;
    logic            wr_req;
    logic            core_take;

    always_comb begin
        base.phase = r_in_first ? dfp_pkg::PH_SKIP1 : r_phase;
        base.cnt   = r_in_first ? '0 : r_cnt;
        base.nfill = r_in_first ? '0 : r_nfill;
        base.cons  = r_in_first ? '0 : r_cons;
        base.we    = 1'b0;
        base.waddr = '0;
        base.burst = 1'b0;
        held_b     = r_in_first ? 8'd0 : r_held;
        drive_b    = r_in_first ? 8'd0 : r_drive;
        up         = to_upper(held_b);

        n_phase   = base.phase;
        n_cnt     = base.cnt;
        n_nfill   = base.nfill;
        n_cons    = base.cons;
        n_held    = held_b;
        n_drive   = drive_b;
        wr_req    = 1'b0;
        o_wr_addr = '0;
        res_bad   = 1'b0;
        res_burst = 1'b0;
        t1        = base;
        t2        = base;

        case (base.phase)
            dfp_pkg::PH_SKIP1: begin
                if (r_in_byte == dfp_pkg::CH_SPACE) begin
                    n_cons = base.cons + 16'd1;
                end else begin
                    n_held  = r_in_byte;
                    n_phase = dfp_pkg::PH_LOOK;
                    wr_req  = 1'b1;
                end
            end
            dfp_pkg::PH_LOOK: begin
                if (r_in_byte == dfp_pkg::CH_COLON) begin
                    if (!drive_ok(up)) begin
                        res_bad = 1'b1;
                        n_phase = dfp_pkg::PH_IDLE;
                    end else begin
                        n_drive = up;
                        n_cons  = base.cons + 16'd2;
                        n_phase = dfp_pkg::PH_SKIP2;
                    end
                end else begin
                    n_drive  = r_default;
                    t1       = base;
                    t1.phase = dfp_pkg::PH_SKIP2;
                    t1       = text_step(t1, held_b);
                    t2       = t1.burst ? t1 : text_step(t1, r_in_byte);
                    // The held byte already sits in entry zero of the store.
                    wr_req    = !t1.burst && t2.we;
                    o_wr_addr = t2.waddr;
                    res_burst = t2.burst;
                    n_phase   = t2.phase;
                    n_cnt     = t2.cnt;
                    n_nfill   = t2.nfill;
                    n_cons    = t2.cons;
                end
            end
            dfp_pkg::PH_SKIP2, dfp_pkg::PH_NAME, dfp_pkg::PH_DOTCHK,
            dfp_pkg::PH_EXT: begin
                t2        = text_step(base, r_in_byte);
                wr_req    = t2.we;
                o_wr_addr = t2.waddr;
                res_burst = t2.burst;
                n_phase   = t2.phase;
                n_cnt     = t2.cnt;
                n_nfill   = t2.nfill;
                n_cons    = t2.cons;
            end
            default: begin
            end
        endcase
    end

    assign core_take   = r_in_valid && !i_emit_busy && !(res_bad && !i_out_free);
    assign o_in_stall  = r_in_valid && !core_take;
    assign o_cfg_ready = 1'b1;
    assign o_wr_data   = r_in_byte;
    assign o_wr_en     = core_take && wr_req;

    always_comb begin
        o_bad.valid      = core_take && res_bad;
        o_bad.drive      = up;
        o_burst.start    = core_take && res_burst;
        o_burst.drive    = n_drive;
        o_burst.consumed = n_cons;
        o_nfill          = n_nfill;
        o_cnt            = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default <= dfp_pkg::DEFAULT_DRIVE_RST;
        end else if (i_cfg_valid) begin
            r_default <= i_cfg_default_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dfp_pkg::PH_IDLE;
            r_held  <= 8'd0;
            r_cnt   <= '0;
            r_nfill <= '0;
            r_cons  <= 16'd0;
            r_drive <= 8'd0;
        end else if (core_take) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_cnt   <= n_cnt;
            r_nfill <= n_nfill;
            r_cons  <= n_cons;
            r_drive <= n_drive;
        end
    end

endmodule

@@ hdl/dfp_emit.sv @@
// ----------------------------------------------------------------------------
// Drive filename parser emitter
// Name store, sequential read-out with padding, and the result register.
// ----------------------------------------------------------------------------
module dfp_emit #(
    parameter int NAME_LEN = dfp_pkg::NAME_LEN_DEF,
    parameter int EXT_LEN  = dfp_pkg::EXT_LEN_DEF,
    localparam int TOTAL   = NAME_LEN + EXT_LEN,
    localparam int AW      = $clog2(TOTAL),
    localparam int CW      = $clog2(TOTAL + 1),
    localparam int NW      = $clog2(NAME_LEN + 1),
    localparam int N_EMIT  = (TOTAL < dfp_pkg::MAX_BEATS) ? TOTAL : dfp_pkg::MAX_BEATS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [7:0]           i_wr_data,
    input  dfp_pkg::t_burst      i_burst,
    input  logic [NW-1:0]        i_nfill,
    input  logic [CW-1:0]        i_cnt,
    input  dfp_pkg::t_bad        i_bad,
    input  logic                 i_out_stall,
    output logic                 o_busy,
    output logic                 o_out_free,
    output logic                 o_out_valid,
    output logic [7:0]           o_char_out,
    output logic [3:0]           o_position,
    output logic [7:0]           o_drive,
    output logic                 o_status,
    output logic [15:0]          o_consumed,
    output logic                 o_last
);

    localparam logic [AW-1:0] LAST_K = AW'(N_EMIT - 1);
    localparam logic [CW-1:0] NAME_C = CW'(NAME_LEN);

    logic [7:0]    mem [TOTAL];
    logic          r_fetch;
    logic [AW-1:0] r_k;
    logic          r_pend;
    logic [AW-1:0] r_pk;
    logic [7:0]    r_rd;
    logic [7:0]    r_b_drive;
    logic [15:0]   r_b_cons;
    logic [NW-1:0] r_b_nfill;
    logic [CW-1:0] r_b_cnt;
    logic          r_ov;
    logic [7:0]    r_char;
    logic [3:0]    r_pos;
    logic [7:0]    r_drv;
    logic          r_st;
    logic [15:0]   r_cons;
    logic          r_last;

    logic          out_load;
    logic          fetch_en;
    logic          filled;
    logic [CW-1:0] pk_w;

    assign o_out_free = !r_ov || !i_out_stall;
    assign out_load   = r_pend && o_out_free;
    assign fetch_en   = r_fetch && (!r_pend || out_load);
    assign o_busy     = r_fetch || r_pend;
    assign pk_w       = CW'(r_pk);
    assign filled     = (pk_w < NAME_C) ? (pk_w < CW'(r_b_nfill)) : (pk_w < r_b_cnt);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fetch_en) begin
            r_rd <= mem[r_k];
            r_pk <= r_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_burst.start) begin
            r_b_drive <= i_burst.drive;
            r_b_cons  <= i_burst.consumed;
            r_b_nfill <= i_nfill;
            r_b_cnt   <= i_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fetch <= 1'b0;
            r_k     <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (i_burst.start) begin
                r_fetch <= 1'b1;
                r_k     <= '0;
            end else if (fetch_en) begin
                r_k <= r_k + AW'(1);
                if (r_k == LAST_K) begin
                    r_fetch <= 1'b0;
                end
            end
            if (fetch_en) begin
                r_pend <= 1'b1;
            end else if (out_load) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load || i_bad.valid) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_char <= filled ? r_rd : dfp_pkg::CH_SPACE;
            r_pos  <= 4'(r_pk);
            r_drv  <= r_b_drive;
            r_st   <= 1'b0;
            r_cons <= r_b_cons;
            r_last <= (r_pk == LAST_K);
        end else if (i_bad.valid) begin
            r_char <= 8'd0;
            r_pos  <= 4'd0;
            r_drv  <= i_bad.drive;
            r_st   <= 1'b1;
            r_cons <= 16'd0;
            r_last <= 1'b1;
        end
    end

    assign o_out_valid = r_ov;
    assign o_char_out  = r_char;
    assign o_position  = r_pos;
    assign o_drive     = r_drv;
    assign o_status    = r_st;
    assign o_consumed  = r_cons;
    assign o_last      = r_last;

endmodule

@@ hdl/drive_filename_parser.sv @@
// ----------------------------------------------------------------------------
// Drive filename parser
// Parses a drive-qualified filename from a byte stream into padded beats.
// ----------------------------------------------------------------------------
// One text byte is taken per clock cycle when not stalled. Bytes that
// complete no filename give no output. The byte that ends a filename starts
// a burst of min(NAME_LEN + EXT_LEN, 16) output beats, one per cycle when the
// output is not stalled; the burst is read from the name store through its
// single read port, and for its length only the one-beat input register
// accepts further bytes. A bad drive letter gives a single beat with status
// set. The name store needs no clearing pass after reset.
module drive_filename_parser #(
    parameter int NAME_LEN = dfp_pkg::NAME_LEN_DEF,
    parameter int EXT_LEN  = dfp_pkg::EXT_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_default_drive,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_char_out,
    output logic [3:0]  o_position,
    output logic [7:0]  o_drive,
    output logic        o_status,
    output logic [15:0] o_consumed,
    output logic        o_last
);

    localparam int TOTAL = NAME_LEN + EXT_LEN;
    localparam int AW    = $clog2(TOTAL);
    localparam int CW    = $clog2(TOTAL + 1);
    localparam int NW    = $clog2(NAME_LEN + 1);

    logic            emit_busy;
    logic            out_free;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;
    dfp_pkg::t_burst burst;
    logic [NW-1:0]   nfill;
    logic [CW-1:0]   cnt;
    dfp_pkg::t_bad   bad;

    dfp_core #(
        .NAME_LEN (NAME_LEN),
        .EXT_LEN  (EXT_LEN)
    ) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_data_byte         (i_data_byte),
        .i_first             (i_first),
        .o_in_stall          (o_in_stall),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_default_drive (i_cfg_default_drive),
        .o_cfg_ready         (o_cfg_ready),
        .i_emit_busy         (emit_busy),
        .i_out_free          (out_free),
        .o_wr_en             (wr_en),
        .o_wr_addr           (wr_addr),
        .o_wr_data           (wr_data),
        .o_burst             (burst),
        .o_nfill             (nfill),
        .o_cnt               (cnt),
        .o_bad               (bad)
    );

    dfp_emit #(
        .NAME_LEN (NAME_LEN),
        .EXT_LEN  (EXT_LEN)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_burst     (burst),
        .i_nfill     (nfill),
        .i_cnt       (cnt),
        .i_bad       (bad),
        .i_out_stall (i_out_stall),
        .o_busy      (emit_busy),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_char_out  (o_char_out),
        .o_position  (o_position),
        .o_drive     (o_drive),
        .o_status    (o_status),
        .o_consumed  (o_consumed),
        .o_last      (o_last)
    );

endmodule

@@ hdl/dfp_checker.sv @@
// ----------------------------------------------------------------------------
// Drive filename parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_char_out,
    input logic [3:0]  o_position,
    input logic [7:0]  o_drive,
    input logic        o_status,
    input logic [15:0] o_consumed,
    input logic        o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_char_out)
            && $stable(o_position))
        else $error("stalled result beat changed");

    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_last && o_char_out == 8'd0
            && o_position == 4'd0 && o_consumed == 16'd0)
        else $error("bad-drive beat malformed");

    a_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> !o_out_valid
            || (o_position == $past(o_position) + 4'd1 && o_drive == $past(o_drive)
                && o_consumed == $past(o_consumed) && !o_status))
        else $error("burst beat out of sequence");

    a_final_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_position == 4'd15 |-> o_last)
        else $error("sixteenth beat not marked last");

endmodule

bind drive_filename_parser dfp_checker u_dfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_char_out  (o_char_out),
    .o_position  (o_position),
    .o_drive     (o_drive),
    .o_status    (o_status),
    .o_consumed  (o_consumed),
    .o_last      (o_last)
);
